// File: rtl/ugpb_pkg.sv
// Shared types and codes for the uniform grid particle binner.
`default_nettype none
package ugpb_pkg;

	typedef enum logic [2:0] {
		OP_WRITE   = 3'd0,
		OP_REBUILD = 3'd1,
		OP_RD_SLOT = 3'd2,
		OP_RD_CELL = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	localparam logic [1:0] CFG_GRID  = 2'd0;
	localparam logic [1:0] CFG_INV   = 2'd1;
	localparam logic [1:0] CFG_COUNT = 2'd2;

	localparam logic [4:0]  GRID_RST  = 5'd16;
	localparam logic [15:0] INV_RST   = 16'd4096;
	localparam logic [10:0] COUNT_RST = 11'd1024;
	localparam logic [11:0] COORD_MAX = 12'd4095;

	typedef struct packed {
		logic [4:0]  grid;
		logic [15:0] inv;
		logic [10:0] count;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic        bad;
		logic [9:0]  boid;
		logic [19:0] px;
		logic [19:0] py;
		logic [19:0] pz;
		logic [11:0] idx;
	} cmd_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} back_ctl_t;

	typedef struct packed {
		logic        ok;
		logic [11:0] cnum;
		logic [9:0]  first;
		logic [9:0]  lst;
		logic [9:0]  id;
		logic        fin;
	} res_t;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_W0, ST_W1, ST_RS0, ST_RS1, ST_RC0, ST_RC1,
		ST_B0, ST_B1, ST_B2, ST_B3, ST_C0, ST_C1, ST_D0, ST_D1, ST_D2,
		ST_Q0, ST_Q1, ST_QN, ST_QC, ST_QF, ST_FIN
	} st_t;

endpackage
`default_nettype wire

// File: rtl/ugpb_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ugpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/ugpb_front.sv
// Front end: accepts items, classifies them and queues commands.
`default_nettype none
module ugpb_front import ugpb_pkg::*; #(
	parameter int MAX_BOIDS = 1024,
	parameter int MAX_GRID  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [9:0]  boid,
	input  wire logic [19:0] pos_x,
	input  wire logic [19:0] pos_y,
	input  wire logic [19:0] pos_z,
	input  wire logic [11:0] index,
	input  wire back_ctl_t   ctl,
	output logic             cmd_v,
	output cmd_t             cmd
);
	localparam int NCELLS = MAX_GRID * MAX_GRID * MAX_GRID;

	cmd_t       fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       acc, push;
	cmd_t       nc;

	assign in_stall = (cnt_q == 2'd2) || ctl.busy;
	assign acc      = in_valid && !in_stall;
	assign push     = acc && (req_type <= 3'(OP_QUERY));
	assign cmd_v    = cnt_q != 2'd0;
	assign cmd      = fifo_q[rd_q];

	always_comb begin
		nc      = '0;
		nc.op   = op_t'(req_type);
		nc.boid = boid;
		nc.px   = pos_x;
		nc.py   = pos_y;
		nc.pz   = pos_z;
		nc.idx  = index;
		unique case (req_type)
			3'(OP_WRITE), 3'(OP_QUERY): nc.bad = 32'(boid) >= 32'(MAX_BOIDS);
			3'(OP_RD_SLOT):             nc.bad = 32'(index) >= 32'(MAX_BOIDS);
			3'(OP_RD_CELL):             nc.bad = 32'(index) >= 32'(NCELLS);
			default:                    nc.bad = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= nc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (ctl.pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(ctl.pop);
		end
	end
endmodule
`default_nettype wire

// File: rtl/ugpb_back.sv
// Back end: sequencer that runs writes, rebuilds, reads and neighbor queries.
`default_nettype none
module ugpb_back import ugpb_pkg::*; #(
	parameter int MAX_BOIDS     = 1024,
	parameter int MAX_GRID      = 16,
	parameter int POS_FRAC_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_v,
	input  wire cmd_t cmd,
	output back_ctl_t ctl,
	input  wire logic out_stall,
	output logic      out_valid,
	output res_t      res
);
	localparam int NCELLS = MAX_GRID * MAX_GRID * MAX_GRID;
	localparam int AW     = $clog2(MAX_BOIDS);
	localparam int NW     = $clog2(MAX_BOIDS + 1);
	localparam int CW     = $clog2(NCELLS);
	localparam int GW     = $clog2(MAX_GRID + 1);
	localparam int SWEEP  = (NCELLS > MAX_BOIDS) ? NCELLS : MAX_BOIDS;
	localparam int KW     = $clog2(SWEEP + 1);
	localparam int SH     = POS_FRAC_BITS + 16;
	localparam int CIW    = 1 + 2 * AW;

	st_t state_q, state_d;

	logic          init_q, have_q, outv_q;
	logic [KW-1:0] k_q;
	logic [1:0]    dx_q, dy_q, dz_q;
	cmd_t          cmd_q;
	logic [NW-1:0] run_q;
	logic [CW-1:0] cell_q;
	logic [35:0]   prx_q, pry_q, prz_q;
	logic [11:0]   cx_q, cy_q, cz_q;
	res_t          hold_q, pend_q, out_q;

	logic           co_we, so_we, ci_we, ta_we, sc_we;
	logic [AW-1:0]  co_wa, co_ra, so_wa, so_ra, sc_wa, sc_ra;
	logic [35:0]    co_wd, co_rd;
	logic [AW-1:0]  so_wd, so_rd;
	logic [CW-1:0]  ci_wa, ci_ra, ta_wa, ta_ra, sc_wd, sc_rd;
	logic [CIW-1:0] ci_wd, ci_rd;
	logic [NW-1:0]  ta_wd, ta_rd;

	logic            push, out_free;
	res_t            push_d, pend_new, hold_new;
	logic [GW-1:0]   g, gm1, xc, yc, zc;
	logic [2*GW-1:0] gg;
	logic [CW:0]     cells;
	logic [NW-1:0]   n;
	logic [CW-1:0]   bcell, qc;
	logic            inb, lastk, hit;
	logic signed [13:0] nx, ny, nz, gs;
	logic [35:0]     vx, vy, vz;
	logic [11:0]     sx, sy, sz;
	logic            ci_full;
	logic [AW-1:0]   ci_first, ci_last;

	ugpb_ram #(.WIDTH(36), .DEPTH(MAX_BOIDS)) u_coords (
		.clk, .we(co_we), .waddr(co_wa), .wdata(co_wd), .raddr(co_ra), .rdata(co_rd));
	ugpb_ram #(.WIDTH(AW), .DEPTH(MAX_BOIDS)) u_sorted (
		.clk, .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));
	ugpb_ram #(.WIDTH(CIW), .DEPTH(NCELLS)) u_cellinfo (
		.clk, .we(ci_we), .waddr(ci_wa), .wdata(ci_wd), .raddr(ci_ra), .rdata(ci_rd));
	ugpb_ram #(.WIDTH(NW), .DEPTH(NCELLS)) u_tally (
		.clk, .we(ta_we), .waddr(ta_wa), .wdata(ta_wd), .raddr(ta_ra), .rdata(ta_rd));
	ugpb_ram #(.WIDTH(CW), .DEPTH(MAX_BOIDS)) u_scratch (
		.clk, .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd));

	assign ci_full  = ci_rd[2*AW];
	assign ci_first = ci_rd[2*AW-1:AW];
	assign ci_last  = ci_rd[AW-1:0];
	assign out_free = !outv_q || !out_stall;
	assign out_valid = outv_q;
	assign res      = out_q;
	assign ctl.busy = init_q;

	// effective grid and particle count
	always_comb begin
		if (cfg.grid == 5'd0) begin
			g = GW'(1);
		end else if (32'(cfg.grid) > 32'(MAX_GRID)) begin
			g = GW'(MAX_GRID);
		end else begin
			g = GW'(cfg.grid);
		end
		gm1   = g - GW'(1);
		gg    = (2*GW)'(g) * (2*GW)'(g);
		cells = (CW+1)'(gg) * (CW+1)'(g);
		if (32'(cfg.count) > 32'(MAX_BOIDS)) begin
			n = NW'(MAX_BOIDS);
		end else begin
			n = NW'(cfg.count);
		end
	end

	// clamped cell of a stored particle during rebuild
	always_comb begin
		xc = (co_rd[11:0] > 12'(gm1))  ? gm1 : GW'(co_rd[11:0]);
		yc = (co_rd[23:12] > 12'(gm1)) ? gm1 : GW'(co_rd[23:12]);
		zc = (co_rd[35:24] > 12'(gm1)) ? gm1 : GW'(co_rd[35:24]);
		bcell = CW'(xc) + CW'(yc) * CW'(g) + CW'(zc) * CW'(gg);
	end

	// neighbor cell of the query walk
	always_comb begin
		gs    = $signed(14'(g));
		nx    = $signed({2'b00, cx_q}) + $signed({12'd0, dx_q}) - 14'sd1;
		ny    = $signed({2'b00, cy_q}) + $signed({12'd0, dy_q}) - 14'sd1;
		nz    = $signed({2'b00, cz_q}) + $signed({12'd0, dz_q}) - 14'sd1;
		inb   = (nx >= 14'sd0) && (nx < gs) && (ny >= 14'sd0) && (ny < gs) &&
			(nz >= 14'sd0) && (nz < gs);
		qc    = CW'(nx[GW-1:0]) + CW'(ny[GW-1:0]) * CW'(g) + CW'(nz[GW-1:0]) * CW'(gg);
		lastk = (dx_q == 2'd2) && (dy_q == 2'd2) && (dz_q == 2'd2);
		hit   = ci_full;
	end

	// cell coordinate saturation
	always_comb begin
		vx = prx_q >> SH;
		vy = pry_q >> SH;
		vz = prz_q >> SH;
		sx = (vx > 36'(COORD_MAX)) ? COORD_MAX : vx[11:0];
		sy = (vy > 36'(COORD_MAX)) ? COORD_MAX : vy[11:0];
		sz = (vz > 36'(COORD_MAX)) ? COORD_MAX : vz[11:0];
	end

	// result words loaded on command pop and on a neighbor hit
	always_comb begin
		pend_new       = '0;
		pend_new.ok    = !cmd.bad;
		pend_new.fin   = 1'b1;
		hold_new       = '0;
		hold_new.ok    = 1'b1;
		hold_new.cnum  = 12'(cell_q);
		hold_new.first = 10'(ci_first);
		hold_new.lst   = 10'(ci_last);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (k_q == KW'(SWEEP - 1)) begin
					if (init_q) state_d = ST_IDLE;
					else if (n == '0) state_d = ST_C0;
					else state_d = ST_B0;
				end
			end
			ST_IDLE: begin
				if (cmd_v) begin
					unique case (cmd.op)
						OP_WRITE:   state_d = cmd.bad ? ST_FIN : ST_W0;
						OP_REBUILD: state_d = ST_CLR;
						OP_RD_SLOT: state_d = cmd.bad ? ST_FIN : ST_RS0;
						OP_RD_CELL: state_d = cmd.bad ? ST_FIN : ST_RC0;
						OP_QUERY:   state_d = cmd.bad ? ST_QF : ST_Q0;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_W0:  state_d = ST_W1;
			ST_W1:  state_d = ST_FIN;
			ST_RS0: state_d = ST_RS1;
			ST_RS1: state_d = ST_FIN;
			ST_RC0: state_d = ST_RC1;
			ST_RC1: state_d = ST_FIN;
			ST_B0:  state_d = ST_B1;
			ST_B1:  state_d = ST_B2;
			ST_B2:  state_d = ST_B3;
			ST_B3:  state_d = (k_q + KW'(1) == KW'(n)) ? ST_C0 : ST_B0;
			ST_C0:  state_d = ST_C1;
			ST_C1: begin
				if (k_q + KW'(1) == KW'(cells)) begin
					state_d = (n == '0) ? ST_FIN : ST_D0;
				end else begin
					state_d = ST_C0;
				end
			end
			ST_D0:  state_d = ST_D1;
			ST_D1:  state_d = ST_D2;
			ST_D2:  state_d = (k_q + KW'(1) == KW'(n)) ? ST_FIN : ST_D0;
			ST_Q0:  state_d = ST_Q1;
			ST_Q1:  state_d = ST_QN;
			ST_QN: begin
				if (inb) state_d = ST_QC;
				else if (lastk) state_d = ST_QF;
			end
			ST_QC: begin
				if (!(hit && have_q && !out_free)) begin
					state_d = lastk ? ST_QF : ST_QN;
				end
			end
			ST_QF:  state_d = out_free ? ST_IDLE : ST_QF;
			ST_FIN: state_d = out_free ? ST_IDLE : ST_FIN;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.pop = 1'b0;
		push    = 1'b0;
		push_d  = pend_q;
		co_we = 1'b0; co_wa = '0; co_wd = '0; co_ra = '0;
		so_we = 1'b0; so_wa = '0; so_wd = '0; so_ra = '0;
		ci_we = 1'b0; ci_wa = '0; ci_wd = '0; ci_ra = '0;
		ta_we = 1'b0; ta_wa = '0; ta_wd = '0; ta_ra = '0;
		sc_we = 1'b0; sc_wa = '0; sc_wd = '0; sc_ra = '0;
		unique case (state_q)
			ST_CLR: begin
				ci_we = 32'(k_q) < 32'(NCELLS);
				ci_wa = CW'(k_q);
				ta_we = 32'(k_q) < 32'(NCELLS);
				ta_wa = CW'(k_q);
				so_we = init_q && (32'(k_q) < 32'(MAX_BOIDS));
				so_wa = AW'(k_q);
				so_wd = AW'(k_q);
			end
			ST_IDLE: ctl.pop = cmd_v;
			ST_W1: begin
				co_we = 1'b1;
				co_wa = AW'(cmd_q.boid);
				co_wd = {sz, sy, sx};
			end
			ST_RS0: so_ra = AW'(cmd_q.idx);
			ST_RC0: ci_ra = CW'(cmd_q.idx);
			ST_B0:  co_ra = AW'(k_q);
			ST_B2:  ta_ra = cell_q;
			ST_B3: begin
				ta_we = 1'b1;
				ta_wa = cell_q;
				ta_wd = ta_rd + NW'(1);
				sc_we = 1'b1;
				sc_wa = AW'(k_q);
				sc_wd = cell_q;
			end
			ST_C0:  ta_ra = CW'(k_q);
			ST_C1: begin
				ta_we = 1'b1;
				ta_wa = CW'(k_q);
				ta_wd = run_q;
				ci_we = ta_rd != '0;
				ci_wa = CW'(k_q);
				ci_wd = {1'b1, AW'(run_q), AW'(run_q + ta_rd - NW'(1))};
			end
			ST_D0:  sc_ra = AW'(k_q);
			ST_D1:  ta_ra = sc_rd;
			ST_D2: begin
				so_we = 1'b1;
				so_wa = AW'(ta_rd);
				so_wd = AW'(k_q);
				ta_we = 1'b1;
				ta_wa = cell_q;
				ta_wd = ta_rd + NW'(1);
			end
			ST_Q0:  co_ra = AW'(cmd_q.boid);
			ST_QN:  ci_ra = qc;
			ST_QC: begin
				ci_ra  = cell_q;
				push   = hit && have_q && out_free;
				push_d = hold_q;
			end
			ST_QF: begin
				push   = out_free;
				push_d = hold_q;
				if (have_q) begin
					push_d.fin = 1'b1;
				end else begin
					push_d     = '0;
					push_d.fin = 1'b1;
				end
			end
			ST_FIN: push = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			init_q  <= 1'b1;
			k_q     <= '0;
			have_q  <= 1'b0;
			dx_q    <= 2'd0;
			dy_q    <= 2'd0;
			dz_q    <= 2'd0;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) outv_q <= 1'b1;
			else if (!out_stall) outv_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					if (k_q == KW'(SWEEP - 1)) begin
						k_q    <= '0;
						init_q <= 1'b0;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_IDLE: begin
					k_q    <= '0;
					have_q <= 1'b0;
					dx_q   <= 2'd0;
					dy_q   <= 2'd0;
					dz_q   <= 2'd0;
				end
				ST_B3: k_q <= (k_q + KW'(1) == KW'(n)) ? '0 : k_q + KW'(1);
				ST_C1: k_q <= (k_q + KW'(1) == KW'(cells)) ? '0 : k_q + KW'(1);
				ST_D2: k_q <= k_q + KW'(1);
				ST_QN, ST_QC: begin
					if ((state_q == ST_QN && !inb) ||
						(state_q == ST_QC && !(hit && have_q && !out_free))) begin
						if (dx_q == 2'd2) begin
							dx_q <= 2'd0;
							if (dy_q == 2'd2) begin
								dy_q <= 2'd0;
								dz_q <= dz_q + 2'd1;
							end else begin
								dy_q <= dy_q + 2'd1;
							end
						end else begin
							dx_q <= dx_q + 2'd1;
						end
					end
					if (state_q == ST_QC && hit && !(have_q && !out_free)) begin
						have_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_d;
		end
		unique case (state_q)
			ST_IDLE: begin
				cmd_q  <= cmd;
				run_q  <= '0;
				pend_q <= pend_new;
			end
			ST_W0: begin
				prx_q <= 36'(cmd_q.px) * 36'(cfg.inv);
				pry_q <= 36'(cmd_q.py) * 36'(cfg.inv);
				prz_q <= 36'(cmd_q.pz) * 36'(cfg.inv);
			end
			ST_RS1: pend_q.id <= 10'(so_rd);
			ST_RC1: begin
				pend_q.ok   <= ci_full;
				pend_q.cnum <= cmd_q.idx;
				pend_q.first <= ci_full ? 10'(ci_first) : 10'd0;
				pend_q.lst   <= ci_full ? 10'(ci_last) : 10'd0;
			end
			ST_B1:  cell_q <= bcell;
			ST_C1:  run_q <= run_q + ta_rd;
			ST_D1:  cell_q <= sc_rd;
			ST_Q1: begin
				cx_q <= co_rd[11:0];
				cy_q <= co_rd[23:12];
				cz_q <= co_rd[35:24];
			end
			ST_QN: begin
				if (inb) cell_q <= qc;
			end
			ST_QC: begin
				if (hit && !(have_q && !out_free)) begin
					hold_q <= hold_new;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/uniform_grid_particle_binner.sv
// Top level of the uniform grid particle binner.
//
//  channel   signals                                   direction
//  in        in_valid/in_stall, req_type..index        item in, stall out
//  out       out_valid/out_stall, ok..last             item out, stall in
//  cfg       cfg_we, cfg_index, cfg_data               write only
//
// Write, read slot, read cell: a valid item steps through pop, two RAM steps and result.
// Rebuild: clear, tally, prefix sum over G^3 cells, then placement (effective count and G).
// Neighbor query: walks the 3x3x3 neighbor cells; in-grid cells go on from ST_QN to ST_QC.
// After reset a clearing pass over max(MAX_GRID^3, MAX_BOIDS) entries holds in_stall high.
// A two-entry command queue lets the front take items while results wait on out_stall.
`default_nettype none
module uniform_grid_particle_binner import ugpb_pkg::*; #(
	parameter int MAX_BOIDS     = 1024,
	parameter int MAX_GRID      = 16,
	parameter int POS_FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [9:0]  boid,
	input  wire logic [19:0] pos_x,
	input  wire logic [19:0] pos_y,
	input  wire logic [19:0] pos_z,
	input  wire logic [11:0] index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic [11:0]      cell_res,
	output logic [9:0]       first_slot,
	output logic [9:0]       last_slot,
	output logic [9:0]       boid_id,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	cfg_t      cfg_q;
	back_ctl_t ctl;
	logic      cmd_v;
	cmd_t      cmd;
	res_t      res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid  <= GRID_RST;
			cfg_q.inv   <= INV_RST;
			cfg_q.count <= COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID:  cfg_q.grid  <= cfg_data[4:0];
				CFG_INV:   cfg_q.inv   <= cfg_data;
				CFG_COUNT: cfg_q.count <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	ugpb_front #(.MAX_BOIDS(MAX_BOIDS), .MAX_GRID(MAX_GRID)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .boid, .pos_x, .pos_y,
		.pos_z, .index, .ctl, .cmd_v, .cmd);

	ugpb_back #(.MAX_BOIDS(MAX_BOIDS), .MAX_GRID(MAX_GRID),
		.POS_FRAC_BITS(POS_FRAC_BITS)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .cmd_v, .cmd, .ctl, .out_stall, .out_valid, .res);

	assign ok         = res.ok;
	assign cell_res   = res.cnum;
	assign first_slot = res.first;
	assign last_slot  = res.lst;
	assign boid_id    = res.id;
	assign last       = res.fin;
endmodule
`default_nettype wire

// File: rtl/ugpb_checker.sv
// Port-level checks for the binner, bound to the top level.
`default_nettype none
module ugpb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       ok,
	input wire logic [9:0] first_slot,
	input wire logic [9:0] last_slot,
	input wire logic [9:0] boid_id,
	input wire logic       last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out item dropped while stalled");

	a_fail_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> last)
		else $error("failed item not final");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> first_slot == 10'd0 && last_slot == 10'd0 && boid_id == 10'd0)
		else $error("failed item carries data");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> first_slot <= last_slot)
		else $error("slot range reversed");
endmodule

bind uniform_grid_particle_binner ugpb_checker u_chk (.*);
`default_nettype wire
